// File: hw/rtl/pfx_pkg.sv
// ----------------------------------------------------------------------------
// pfx_pkg
// Shared types and constants for the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pfx_pkg;

   localparam int STACK_DEPTH_DEFAULT = 16;
   localparam int DATA_W              = 32;
   localparam int STATUS_W            = 3;
   localparam int CHAR_W              = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'd42;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'd47;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              end_of_expr;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] result;
   } alu_rsp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ,
      SEQ_WAIT,
      SEQ_FINISH
   } seq_state_type;

endpackage

// File: hw/rtl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression streamed one character per transaction.
// ----------------------------------------------------------------------------
// Digits push 0..9; + - * / pop two entries and push second-op-top with
// 32-bit wrapping arithmetic and division truncated toward zero; other
// characters are ignored. The transaction carrying end_of_expr yields one
// response with the top of stack and a status (ok, underflow, divide by
// zero, overflow, empty), after which the stack and status clear. A digit
// or ignored character is taken in the idle state; + - * pass through a
// stack read, the shared unit and a write back, and / also waits on the
// one-bit-per-cycle divider in the shared arithmetic unit. A final character
// then loads the response register in a finish state that waits while the
// response is stalled; req_stall is high while a transaction is in progress.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfx_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int DW    = pfx_pkg::DATA_W;

   pfx_pkg::seq_state_type state_ff, state_in;
   logic [CNT_W-1:0]           count_ff,     count_in;
   logic [pfx_pkg::STATUS_W-1:0] status_ff,  status_in;
   logic [DW-1:0]              top_ff,       top_in;
   pfx_pkg::alu_op_type        op_ff,        op_in;
   logic                       last_ff,      last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pfx_pkg::rsp_type           rsp_data_ff,  rsp_data_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [DW-1:0]        wr_data;
   logic [IDX_W-1:0]     second_addr;
   logic [CNT_W-1:0]     count_minus2;
   logic [DW-1:0]        second_data;
   logic [DW-1:0]        digit_value;
   logic                 is_digit;
   logic                 is_op;
   logic                 go_read;
   pfx_pkg::alu_op_type  op_decoded;
   pfx_pkg::alu_req_type alu_req;
   pfx_pkg::alu_rsp_type alu_rsp;

   assign count_minus2 = count_ff - CNT_W'(2);
   assign second_addr  = count_minus2[IDX_W-1:0];
   assign digit_value  = DW'(req_data.char_code - pfx_pkg::DIGIT_BASE);
   assign is_digit     = (req_data.char_code >= pfx_pkg::CHAR_ZERO) &&
                         (req_data.char_code <= pfx_pkg::CHAR_NINE);

   always_comb begin
      is_op      = 1'b1;
      op_decoded = pfx_pkg::ALU_ADD;
      case (req_data.char_code)
         pfx_pkg::CHAR_PLUS:  op_decoded = pfx_pkg::ALU_ADD;
         pfx_pkg::CHAR_MINUS: op_decoded = pfx_pkg::ALU_SUB;
         pfx_pkg::CHAR_STAR:  op_decoded = pfx_pkg::ALU_MUL;
         pfx_pkg::CHAR_SLASH: op_decoded = pfx_pkg::ALU_DIV;
         default:             is_op      = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      top_in        = top_ff;
      op_in         = op_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = digit_value;
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;
      go_read       = 1'b0;
      req_stall     = (state_ff != pfx_pkg::SEQ_IDLE);

      unique case (state_ff)
         pfx_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               last_in = req_data.end_of_expr;
               if (status_ff == pfx_pkg::ST_OK) begin
                  if (is_digit) begin
                     if (count_ff == CNT_W'(STACK_DEPTH)) begin
                        status_in = pfx_pkg::ST_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        top_in   = digit_value;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end else if (is_op) begin
                     if (count_ff < CNT_W'(2)) begin
                        status_in = pfx_pkg::ST_UNDERFLOW;
                     end else begin
                        op_in   = op_decoded;
                        go_read = 1'b1;
                     end
                  end
               end
               if (go_read) begin
                  state_in = pfx_pkg::SEQ_READ;
               end else if (req_data.end_of_expr) begin
                  state_in = pfx_pkg::SEQ_FINISH;
               end
            end
         end
         pfx_pkg::SEQ_READ: begin
            if (op_ff == pfx_pkg::ALU_DIV && top_ff == '0) begin
               status_in = pfx_pkg::ST_DIVZERO;
               state_in  = last_ff ? pfx_pkg::SEQ_FINISH : pfx_pkg::SEQ_IDLE;
            end else begin
               alu_req.start = 1'b1;
               state_in      = pfx_pkg::SEQ_WAIT;
            end
         end
         pfx_pkg::SEQ_WAIT: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = second_addr;
               wr_data  = alu_rsp.result;
               top_in   = alu_rsp.result;
               count_in = count_ff - CNT_W'(1);
               state_in = last_ff ? pfx_pkg::SEQ_FINISH : pfx_pkg::SEQ_IDLE;
            end
         end
         pfx_pkg::SEQ_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (status_ff != pfx_pkg::ST_OK) begin
                  rsp_data_in.result_value = '0;
                  rsp_data_in.status       = status_ff;
               end else if (count_ff == '0) begin
                  rsp_data_in.result_value = '0;
                  rsp_data_in.status       = pfx_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in.result_value = top_ff;
                  rsp_data_in.status       = pfx_pkg::ST_OK;
               end
               count_in  = '0;
               status_in = pfx_pkg::ST_OK;
               state_in  = pfx_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = pfx_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfx_pkg::SEQ_IDLE;
         count_ff     <= '0;
         status_ff    <= pfx_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      op_ff       <= op_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   pfx_stack #(
      .DEPTH (STACK_DEPTH),
      .IDX_W (IDX_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (second_addr),
      .rd_data (second_data)
   );

   pfx_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .lhs     (second_data),
      .rhs     (top_ff),
      .alu_rsp (alu_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/pfx_stack.sv
// ----------------------------------------------------------------------------
// pfx_stack
// Operand stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfx_stack #(
   parameter int DEPTH = pfx_pkg::STACK_DEPTH_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [IDX_W-1:0]          wr_addr,
   input  logic [pfx_pkg::DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]          rd_addr,
   output logic [pfx_pkg::DATA_W-1:0] rd_data
);

   logic [pfx_pkg::DATA_W-1:0] mem [DEPTH];
   logic [pfx_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/pfx_alu.sv
// ----------------------------------------------------------------------------
// pfx_alu
// Shared arithmetic unit: registered add, subtract and multiply, and a
// radix-2 restoring divider that truncates toward zero.
// ----------------------------------------------------------------------------
module pfx_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  pfx_pkg::alu_req_type       alu_req,
   input  logic [pfx_pkg::DATA_W-1:0] lhs,
   input  logic [pfx_pkg::DATA_W-1:0] rhs,
   output pfx_pkg::alu_rsp_type       alu_rsp
);

   localparam int DW    = pfx_pkg::DATA_W;
   localparam int CNT_W = $clog2(DW);

   logic             busy_ff,   busy_in;
   logic             done_ff,   done_in;
   logic [CNT_W-1:0] iter_ff,   iter_in;
   logic [DW-1:0]    rem_ff,    rem_in;
   logic [DW-1:0]    quo_ff,    quo_in;
   logic [DW-1:0]    den_ff,    den_in;
   logic             neg_ff,    neg_in;
   logic [DW-1:0]    result_ff, result_in;

   logic [DW:0]   shifted;
   logic [DW:0]   diff;
   logic [DW-1:0] quo_next;
   logic [DW-1:0] lhs_mag;
   logic [DW-1:0] rhs_mag;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      iter_in   = iter_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      neg_in    = neg_ff;
      result_in = result_ff;

      lhs_mag  = lhs[DW-1] ? (DW'(0) - lhs) : lhs;
      rhs_mag  = rhs[DW-1] ? (DW'(0) - rhs) : rhs;
      shifted  = {rem_ff, quo_ff[DW-1]};
      diff     = shifted - {1'b0, den_ff};
      quo_next = {quo_ff[DW-2:0], ~diff[DW]};

      if (busy_ff) begin
         rem_in  = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
         quo_in  = quo_next;
         iter_in = iter_ff - CNT_W'(1);
         if (iter_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? (DW'(0) - quo_next) : quo_next;
         end
      end else if (alu_req.start) begin
         unique case (alu_req.op)
            pfx_pkg::ALU_ADD: begin
               result_in = lhs + rhs;
               done_in   = 1'b1;
            end
            pfx_pkg::ALU_SUB: begin
               result_in = lhs - rhs;
               done_in   = 1'b1;
            end
            pfx_pkg::ALU_MUL: begin
               result_in = DW'(lhs * rhs);
               done_in   = 1'b1;
            end
            pfx_pkg::ALU_DIV: begin
               busy_in = 1'b1;
               iter_in = CNT_W'(DW - 1);
               rem_in  = '0;
               quo_in  = lhs_mag;
               den_in  = rhs_mag;
               neg_in  = lhs[DW-1] ^ rhs[DW-1];
            end
            default: begin
               done_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff   <= iter_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      den_ff    <= den_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;

endmodule

// File: verif/tb_postfix_expression_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_expression_evaluator
// Self-checking testbench for the postfix expression evaluator.
// ----------------------------------------------------------------------------
// A short table of directed characters (field extremes, every operator,
// underflow, divide by zero, sticky errors, empty stack at end) is followed
// by random expressions: mostly well-formed postfix strings with random
// content, plus mutated strings, noise, deep stacks, stack overflow and the
// most-negative-by-minus-one quotient. Every accepted character runs through
// a local evaluator; each response is compared with the oldest expected one.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_postfix_expression_evaluator;

   localparam int          DEPTH        = pfx_pkg::STACK_DEPTH_DEFAULT;
   localparam int          RANDOM_ITEMS = 1100;
   localparam int          CYCLE_LIMIT  = 2000000;
   localparam int          END_WAIT     = 40;
   localparam logic [7:0]  SPACE_CHAR   = 8'h20;

   typedef struct packed {
      pfx_pkg::req_type tr;
      logic             typed;
      pfx_pkg::rsp_type want;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [0:23] = '{
      '{'{8'h00, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_PLUS, 1'b1}, 1'b1, '{32'sd0, pfx_pkg::ST_UNDERFLOW}},
      '{'{8'hFF, 1'b1}, 1'b1, '{32'sd0, pfx_pkg::ST_EMPTY}},
      '{'{pfx_pkg::CHAR_NINE, 1'b1}, 1'b1, '{32'sd9, pfx_pkg::ST_OK}},
      '{'{pfx_pkg::CHAR_ZERO + 8'd1, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd2, 1'b1}, 1'b1, '{32'sd2, pfx_pkg::ST_OK}},
      '{'{pfx_pkg::CHAR_PLUS, 1'b1}, 1'b1, '{32'sd0, pfx_pkg::ST_UNDERFLOW}},
      '{'{pfx_pkg::CHAR_ZERO, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_SLASH, 1'b1}, 1'b1, '{32'sd0, pfx_pkg::ST_DIVZERO}},
      '{'{pfx_pkg::CHAR_ZERO + 8'd8, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd3, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_MINUS, 1'b1}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd3, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd8, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_MINUS, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd2, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_SLASH, 1'b1}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_STAR, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd5, 1'b0}, 1'b0, '0},
      '{'{SPACE_CHAR, 1'b1}, 1'b1, '{32'sd0, pfx_pkg::ST_UNDERFLOW}},
      '{'{pfx_pkg::CHAR_ZERO + 8'd7, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_ZERO + 8'd6, 1'b0}, 1'b0, '0},
      '{'{pfx_pkg::CHAR_STAR, 1'b1}, 1'b0, '0}
   };

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pfx_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pfx_pkg::rsp_type rsp_data;

   pfx_pkg::rsp_type pending_results [$];
   pfx_pkg::req_type expr_q [$];
   logic [31:0]      calc_stack [DEPTH];
   int unsigned      calc_depth  = 0;
   logic [2:0]       calc_error  = pfx_pkg::ST_OK;
   int unsigned      chars_sent  = 0;
   int unsigned      fail_count  = 0;
   int unsigned      cycle_count = 0;
   int unsigned      rsp_hold    = 0;
   int unsigned      rsp_calm    = 0;

   postfix_expression_evaluator DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit is_digit(input logic [7:0] c);
      return c >= pfx_pkg::CHAR_ZERO && c <= pfx_pkg::CHAR_NINE;
   endfunction

   function automatic bit is_operator(input logic [7:0] c);
      return c == pfx_pkg::CHAR_PLUS || c == pfx_pkg::CHAR_MINUS ||
             c == pfx_pkg::CHAR_STAR || c == pfx_pkg::CHAR_SLASH;
   endfunction

   // Advance the local evaluator by one character; returns 1 when a response is due.
   function automatic bit eval_char(input pfx_pkg::req_type tr,
                                    output pfx_pkg::rsp_type res);
      logic [31:0] top, second, value, mag_s, mag_t, quot;
      res = '0;
      value = '0;
      if (calc_error == pfx_pkg::ST_OK) begin
         if (is_digit(tr.char_code)) begin
            if (calc_depth >= DEPTH) begin
               calc_error = pfx_pkg::ST_OVERFLOW;
            end else begin
               calc_stack[calc_depth] = {24'd0, tr.char_code - pfx_pkg::DIGIT_BASE};
               calc_depth++;
            end
         end else if (is_operator(tr.char_code)) begin
            if (calc_depth < 2) begin
               calc_error = pfx_pkg::ST_UNDERFLOW;
            end else begin
               top    = calc_stack[calc_depth - 1];
               second = calc_stack[calc_depth - 2];
               case (tr.char_code)
                  pfx_pkg::CHAR_PLUS:  value = second + top;
                  pfx_pkg::CHAR_MINUS: value = second - top;
                  pfx_pkg::CHAR_STAR:  value = second * top;
                  default: begin
                     if (top == '0) begin
                        calc_error = pfx_pkg::ST_DIVZERO;
                     end else begin
                        mag_s = second[31] ? -second : second;
                        mag_t = top[31] ? -top : top;
                        quot  = mag_s / mag_t;
                        value = (second[31] ^ top[31]) ? -quot : quot;
                     end
                  end
               endcase
               if (calc_error == pfx_pkg::ST_OK) begin
                  calc_stack[calc_depth - 2] = value;
                  calc_depth--;
               end
            end
         end
      end
      if (!tr.end_of_expr) return 1'b0;
      res.status = calc_error;
      if (calc_error == pfx_pkg::ST_OK) begin
         if (calc_depth == 0) res.status = pfx_pkg::ST_EMPTY;
         else res.result_value = calc_stack[calc_depth - 1];
      end
      calc_depth = 0;
      calc_error = pfx_pkg::ST_OK;
      return 1'b1;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic pfx_pkg::req_type make_char(input logic [7:0] c);
      pfx_pkg::req_type tr;
      tr.char_code   = c;
      tr.end_of_expr = 1'b0;
      return tr;
   endfunction

   function automatic void push_char(input logic [7:0] c);
      expr_q.push_back(make_char(c));
   endfunction

   function automatic logic [7:0] rand_digit();
      return pfx_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] rand_op();
      case ($urandom_range(0, 3))
         0:       return pfx_pkg::CHAR_PLUS;
         1:       return pfx_pkg::CHAR_MINUS;
         2:       return pfx_pkg::CHAR_STAR;
         default: return pfx_pkg::CHAR_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] rand_ignored();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (is_digit(c) || is_operator(c));
      return c;
   endfunction

   function automatic void build_wellformed(input int unsigned lim, input int unsigned n_ops);
      int unsigned level, ops_done;
      level    = 0;
      ops_done = 0;
      while (ops_done < n_ops || level != 1) begin
         if (level < 2 || (level < lim && ops_done < n_ops && $urandom_range(0, 1) == 1)) begin
            push_char(rand_digit());
            level++;
         end else begin
            push_char(rand_op());
            level--;
            ops_done++;
         end
         if ($urandom_range(0, 11) == 0) push_char(rand_ignored());
      end
   endfunction

   function automatic void mutate_expr();
      int unsigned idx;
      idx = $urandom_range(0, expr_q.size() - 1);
      case ($urandom_range(0, 2))
         0:       expr_q.delete(idx);
         1:       expr_q.insert(idx, make_char(rand_op()));
         default: expr_q.insert(idx, make_char(rand_digit()));
      endcase
   endfunction

   function automatic void build_noise();
      int unsigned n;
      n = $urandom_range(1, 12);
      repeat (n) begin
         if ($urandom_range(0, 1) == 1) push_char(8'($urandom_range(0, 255)));
         else if ($urandom_range(0, 1) == 1) push_char(rand_digit());
         else push_char(rand_op());
         if ($urandom_range(0, 9) == 0) expr_q[expr_q.size() - 1].end_of_expr = 1'b1;
      end
   endfunction

   function automatic void build_deep();
      repeat (DEPTH) push_char(pfx_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(0, DEPTH - 1)) push_char(rand_op());
   endfunction

   function automatic void build_overflow();
      repeat ($urandom_range(DEPTH + 1, DEPTH + 3)) push_char(rand_digit());
      repeat ($urandom_range(0, 2)) push_char(rand_op());
   endfunction

   // -8 * 8^9 * 2 = -2^31, then divide by -1.
   function automatic void build_min_div();
      push_char(pfx_pkg::CHAR_ZERO);
      push_char(pfx_pkg::CHAR_ZERO + 8'd8);
      push_char(pfx_pkg::CHAR_MINUS);
      repeat (9) begin
         push_char(pfx_pkg::CHAR_ZERO + 8'd8);
         push_char(pfx_pkg::CHAR_STAR);
      end
      push_char(pfx_pkg::CHAR_ZERO + 8'd2);
      push_char(pfx_pkg::CHAR_STAR);
      push_char(pfx_pkg::CHAR_ZERO);
      push_char(pfx_pkg::CHAR_ZERO + 8'd1);
      push_char(pfx_pkg::CHAR_MINUS);
      push_char(pfx_pkg::CHAR_SLASH);
   endfunction

   function automatic void close_expr();
      if (expr_q.size() == 0 || $urandom_range(0, 5) == 0) push_char(rand_ignored());
      expr_q[expr_q.size() - 1].end_of_expr = 1'b1;
   endfunction

   task automatic send_char(input pfx_pkg::req_type tr, input bit calm, input bit typed,
                            input pfx_pkg::rsp_type typed_rsp);
      pfx_pkg::rsp_type want;
      int unsigned      gap;
      req_valid <= 1'b1;
      req_data  <= tr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (eval_char(tr, want)) pending_results.push_back(typed ? typed_rsp : want);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic play_expr(input bit calm);
      pfx_pkg::req_type tr;
      while (expr_q.size() != 0) begin
         tr = expr_q.pop_front();
         chars_sent++;
         send_char(tr, calm, 1'b0, '0);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_side
      pfx_pkg::rsp_type want;
      int unsigned      gap;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected transaction: result_value %0d status %0d",
                      rsp_data.result_value, rsp_data.status);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.result_value !== want.result_value) begin
                  $error("result_value: expected %0d, got %0d",
                         want.result_value, rsp_data.result_value);
                  fail_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  fail_count++;
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
         end else if (rsp_calm > 0) begin
            rsp_calm--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_calm = $urandom_range(100, 300);
            rsp_stall <= 1'b0;
         end else begin
            gap = pick_gap();
            rsp_stall <= (gap > 0);
            if (gap > 0) rsp_hold = gap - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int unsigned pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_TABLE[i]) send_char(DIR_TABLE[i].tr, 1'b0, DIR_TABLE[i].typed,
                                       DIR_TABLE[i].want);
      drain_results();

      build_min_div();
      close_expr();
      play_expr(1'b0);
      build_overflow();
      close_expr();
      play_expr(1'b1);

      while (chars_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 24) == 0) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 58) begin
            build_wellformed($urandom_range(2, DEPTH), $urandom_range(0, 12));
         end else if (pick < 72) begin
            build_wellformed($urandom_range(2, DEPTH), $urandom_range(0, 8));
            mutate_expr();
         end else if (pick < 86) begin
            build_noise();
         end else if (pick < 93) begin
            build_deep();
         end else if (pick < 97) begin
            build_overflow();
         end else begin
            build_min_div();
         end
         close_expr();
         play_expr($urandom_range(0, 9) == 0);
      end

      drain_results();
      repeat (END_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
